/* design/mmt_pkg.sv */
// Shared types and constants of the matrix multiply engine.
package mmt_pkg;

    localparam int OP_W    = 2;
    localparam int POS_W   = 6;
    localparam int VALUE_W = 16;
    localparam int SUM_W   = 38;
    localparam int CFG_W   = 7;
    localparam int CFG_IDX_W = 3;

    typedef enum logic [OP_W-1:0] {
        OP_WRITE_A = 2'd0,
        OP_WRITE_B = 2'd1,
        OP_COMPUTE = 2'd2,
        OP_NONE    = 2'd3
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROWS_OUT    = 3'd0,
        CFG_INNER_SIZE  = 3'd1,
        CFG_COLS_OUT    = 3'd2,
        CFG_TRANSPOSE_A = 3'd3,
        CFG_TRANSPOSE_B = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic shift;
        logic tail;
    } t_cell_ctrl;

endpackage

/* design/mmt_if.sv */
// Valid/ready channel interfaces for input items and result items.
interface mmt_in_if;
    logic                                 valid;
    logic                                 ready;
    logic [mmt_pkg::OP_W-1:0]             operation;
    logic [mmt_pkg::POS_W-1:0]            row;
    logic [mmt_pkg::POS_W-1:0]            col;
    logic signed [mmt_pkg::VALUE_W-1:0]   value;

    modport source (output valid, output operation, output row, output col, output value,
                    input ready);
    modport sink (input valid, input operation, input row, input col, input value,
                  output ready);
endinterface

interface mmt_out_if;
    logic                                 valid;
    logic                                 ready;
    logic [mmt_pkg::POS_W-1:0]            out_col;
    logic signed [mmt_pkg::SUM_W-1:0]     sum;
    logic                                 last;

    modport source (output valid, output out_col, output sum, output last, input ready);
    modport sink (input valid, input out_col, input sum, input last, output ready);
endinterface

/* design/mmt_cell.sv */
// One cell of the A-row chain: holds one element and passes it towards the head.
module mmt_cell #(
    parameter int EW = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  mmt_pkg::t_cell_ctrl     i_ctrl,
    input  logic signed [EW-1:0]    i_next,
    input  logic signed [EW-1:0]    i_tail_data,
    output logic signed [EW-1:0]    o_data
);

    logic signed [EW-1:0] r_data;
    logic signed [EW-1:0] n_data;

    always_comb begin
        n_data = r_data;
        if (i_ctrl.shift) begin
            n_data = i_ctrl.tail ? i_tail_data : i_next;
        end
    end

    // payload only: reset leaves it alone
    always_ff @(posedge i_clk) begin
        if (i_rst_n || !i_rst_n) begin
            r_data <= n_data;
        end
    end

    assign o_data = r_data;

endmodule

/* design/matrix_multiply_transpose_modes.sv */
// Compute row: load A'(i,*) into the cell chain, then per column run COMP, DRAIN and EMIT.
// Within COMP a compute item does one multiply-accumulate per cycle,
// set by the single B store read port. Loads of A or B write one element each.
// Compute items whose row is out of range, and unused operations, are taken and give nothing.
// Synchronous active-low reset: control registers return to m=k=n=64, no transposes, idle;
// A and B stores are not cleared and must be written before they are read.
module matrix_multiply_transpose_modes #(
    parameter int MAX_DIM    = 64,
    parameter int ELEM_WIDTH = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    mmt_in_if.sink                              i_in,
    mmt_out_if.source                           o_out,
    input  logic                                i_cfg_we,
    input  logic [mmt_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [mmt_pkg::CFG_W-1:0]           i_cfg_data
);

    localparam int EW = ELEM_WIDTH;
    localparam int IW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int DW = $clog2(MAX_DIM + 1);
    localparam int AW = 2 * IW;
    localparam int NPOS = 2 ** mmt_pkg::POS_W;

    typedef logic [IW-1:0] t_mod_tbl [NPOS];

    function automatic t_mod_tbl build_mod();
        t_mod_tbl tbl;
        for (int p = 0; p < NPOS; p++) begin
            tbl[p] = IW'(p % MAX_DIM);
        end
        return tbl;
    endfunction

    localparam t_mod_tbl MOD_TBL = build_mod();

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_ALOAD = 5'b00010,
        ST_COMP  = 5'b00100,
        ST_DRAIN = 5'b01000,
        ST_EMIT  = 5'b10000
    } t_state;

    // configuration
    logic [mmt_pkg::CFG_W-1:0] r_rows, r_inner, r_cols;
    logic                      r_ta, r_tb;
    logic [DW-1:0]             dim_m, dim_k, dim_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows  <= mmt_pkg::CFG_W'(64);
            r_inner <= mmt_pkg::CFG_W'(64);
            r_cols  <= mmt_pkg::CFG_W'(64);
            r_ta    <= 1'b0;
            r_tb    <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                mmt_pkg::CFG_ROWS_OUT:    r_rows  <= i_cfg_data;
                mmt_pkg::CFG_INNER_SIZE:  r_inner <= i_cfg_data;
                mmt_pkg::CFG_COLS_OUT:    r_cols  <= i_cfg_data;
                mmt_pkg::CFG_TRANSPOSE_A: r_ta    <= i_cfg_data[0];
                mmt_pkg::CFG_TRANSPOSE_B: r_tb    <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign dim_m = (int'(r_rows)  > MAX_DIM) ? DW'(MAX_DIM) : DW'(r_rows);
    assign dim_k = (int'(r_inner) > MAX_DIM) ? DW'(MAX_DIM) : DW'(r_inner);
    assign dim_n = (int'(r_cols)  > MAX_DIM) ? DW'(MAX_DIM) : DW'(r_cols);

    logic [IW-1:0] k_last, n_last;
    assign k_last = IW'(dim_k - DW'(1));
    assign n_last = IW'(dim_n - DW'(1));

    // sequencer
    t_state        r_state, n_state;
    logic [IW-1:0] r_row, n_row;
    logic [IW-1:0] r_t, n_t;
    logic [IW-1:0] r_j, n_j;

    logic in_xfer, out_xfer, out_free;
    logic [IW-1:0] in_r, in_c;
    logic signed [EW-1:0] in_elem;

    assign i_in.ready = (r_state == ST_IDLE);
    assign in_xfer    = i_in.valid && i_in.ready;
    assign out_xfer   = o_out.valid && o_out.ready;
    assign out_free   = !o_out.valid || o_out.ready;
    assign in_r       = MOD_TBL[i_in.row];
    assign in_c       = MOD_TBL[i_in.col];
    assign in_elem    = EW'(i_in.value);

    logic a_issue, b_issue;
    logic r_pv, r_plast;
    logic emit;

    always_comb begin
        n_state = r_state;
        n_row   = r_row;
        n_t     = r_t;
        n_j     = r_j;
        a_issue = 1'b0;
        b_issue = 1'b0;
        emit    = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (in_xfer && i_in.operation == mmt_pkg::OP_COMPUTE
                    && int'(i_in.row) < int'(dim_m) && dim_n != '0) begin
                    n_row = in_r;
                    n_t   = '0;
                    n_j   = '0;
                    n_state = (dim_k == '0) ? ST_EMIT : ST_ALOAD;
                end
            end
            ST_ALOAD: begin
                a_issue = 1'b1;
                n_t     = r_t + IW'(1);
                if (r_t == k_last) begin
                    n_t     = '0;
                    n_state = ST_COMP;
                end
            end
            ST_COMP: begin
                b_issue = 1'b1;
                n_t     = r_t + IW'(1);
                if (r_t == k_last) begin
                    n_t     = '0;
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (r_pv && r_plast) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    emit = 1'b1;
                    if (r_j == n_last) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_j     = r_j + IW'(1);
                        n_state = (dim_k == '0) ? ST_EMIT : ST_COMP;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_t     <= '0;
            r_j     <= '0;
        end else begin
            r_state <= n_state;
            r_t     <= n_t;
            r_j     <= n_j;
        end
        r_row <= n_row;
    end

    // stores
    logic signed [EW-1:0] a_mem [2**AW];
    logic signed [EW-1:0] b_mem [2**AW];
    logic signed [EW-1:0] r_a_rdata, r_b_rdata;
    logic [AW-1:0]        a_raddr, b_raddr;

    assign a_raddr = r_ta ? {r_t, r_row} : {r_row, r_t};
    assign b_raddr = r_tb ? {r_j, r_t} : {r_t, r_j};

    always_ff @(posedge i_clk) begin
        if (in_xfer && i_in.operation == mmt_pkg::OP_WRITE_A) begin
            a_mem[{in_r, in_c}] <= in_elem;
        end
        r_a_rdata <= a_mem[a_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer && i_in.operation == mmt_pkg::OP_WRITE_B) begin
            b_mem[{in_r, in_c}] <= in_elem;
        end
        r_b_rdata <= b_mem[b_raddr];
    end

    // pipeline flags
    logic r_av, r_bv, r_bfirst, r_blast, r_pfirst;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_av <= 1'b0;
            r_bv <= 1'b0;
            r_pv <= 1'b0;
        end else begin
            r_av <= a_issue;
            r_bv <= b_issue;
            r_pv <= r_bv;
        end
        r_bfirst <= (r_t == '0);
        r_blast  <= (r_t == k_last);
        r_pfirst <= r_bfirst;
        r_plast  <= r_blast;
    end

    // cell chain: rotate on each B element, shift in A on each A element
    logic signed [EW-1:0] cell_data [MAX_DIM];
    logic signed [EW-1:0] tail_data;
    logic signed [EW-1:0] head;

    assign head      = cell_data[0];
    assign tail_data = r_av ? r_a_rdata : head;

    for (genvar p = 0; p < MAX_DIM; p++) begin : g_cell
        mmt_pkg::t_cell_ctrl  ctrl;
        logic signed [EW-1:0] next_data;

        assign ctrl.shift = r_av || r_bv;
        assign ctrl.tail  = (IW'(p) == k_last);
        if (p == MAX_DIM - 1) begin : g_end
            assign next_data = '0;
        end else begin : g_mid
            assign next_data = cell_data[p+1];
        end

        mmt_cell #(.EW(EW)) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctrl      (ctrl),
            .i_next      (next_data),
            .i_tail_data (tail_data),
            .o_data      (cell_data[p])
        );
    end

    // multiply, then accumulate
    logic signed [2*EW-1:0]            r_prod;
    logic signed [mmt_pkg::SUM_W-1:0]  r_acc;

    always_ff @(posedge i_clk) begin
        if (r_bv) begin
            r_prod <= head * r_b_rdata;
        end
        if (r_state == ST_IDLE) begin
            r_acc <= '0;
        end else if (r_pv) begin
            r_acc <= (r_pfirst ? '0 : r_acc) + mmt_pkg::SUM_W'(r_prod);
        end
    end

    // result register
    logic                              r_out_valid;
    logic [mmt_pkg::POS_W-1:0]         r_out_col;
    logic signed [mmt_pkg::SUM_W-1:0]  r_out_sum;
    logic                              r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (out_xfer) begin
            r_out_valid <= 1'b0;
        end
        if (emit) begin
            r_out_col  <= mmt_pkg::POS_W'(r_j);
            r_out_sum  <= r_acc;
            r_out_last <= (r_j == n_last);
        end
    end

    assign o_out.valid   = r_out_valid;
    assign o_out.out_col = r_out_col;
    assign o_out.sum     = r_out_sum;
    assign o_out.last    = r_out_last;

endmodule
